[design/hsr_pkg.sv]
// shared types and constants of the handle slot registry
package hsr_pkg;

   localparam int unsigned HANDLE_W      = 32;
   localparam int unsigned TAG_W         = 32;
   localparam int unsigned OCC_W         = 7;
   localparam int unsigned DEFAULT_SLOTS = 64;
   localparam int unsigned QUEUE_DEPTH   = 2;

   localparam logic [HANDLE_W-1:0] HANDLE_MAX = 32'hFFFF_FFFF;

   typedef enum logic [1:0] {
      REQ_REGISTER   = 2'd0,
      REQ_UNREGISTER = 2'd1,
      REQ_LOOKUP     = 2'd2,
      REQ_COUNT      = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2
   } status_type;

   typedef struct packed {
      req_code_type        code;
      logic [HANDLE_W-1:0] handle;
      logic [TAG_W-1:0]    tag;
   } req_cmd_type;

   typedef struct packed {
      logic                valid;
      logic [HANDLE_W-1:0] handle;
      logic [TAG_W-1:0]    tag;
   } slot_entry_type;

endpackage

[design/hsr_req_if.sv]
// request channel of the handle slot registry
interface hsr_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   req_type;
   logic [hsr_pkg::HANDLE_W-1:0] handle_in;
   logic [hsr_pkg::TAG_W-1:0]    ctx_tag;

   modport source (output valid, output req_type, output handle_in, output ctx_tag,
                   input ready);
   modport sink   (input valid, input req_type, input handle_in, input ctx_tag,
                   output ready);
endinterface

[design/hsr_rsp_if.sv]
// response channel of the handle slot registry
interface hsr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic [hsr_pkg::HANDLE_W-1:0] handle_out;
   logic [hsr_pkg::TAG_W-1:0]    tag_out;
   logic [hsr_pkg::OCC_W-1:0]    occupied;

   modport source (output valid, output status, output handle_out, output tag_out,
                   output occupied, input ready);
   modport sink   (input valid, input status, input handle_out, input tag_out,
                   input occupied, output ready);
endinterface

[design/hsr_ram.sv]
// generic single write port, single read port ram with registered read
module hsr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

[design/hsr_front.sv]
// front end: accepts requests and reduces the handle of unregister and lookup requests to its slot index
module hsr_front #(
   parameter int unsigned SLOTS = hsr_pkg::DEFAULT_SLOTS
) (
   input  logic                       clock,
   input  logic                       reset,
   hsr_req_if.sink                    req,
   input  logic                       clear_busy,
   output logic                       push_valid,
   input  logic                       push_ready,
   output hsr_pkg::req_cmd_type       push_cmd,
   output logic [$clog2(SLOTS)-1:0]   push_idx
);

   localparam int unsigned IW = $clog2(SLOTS);
   localparam int unsigned HW = hsr_pkg::HANDLE_W;
   localparam int unsigned PW = 2 * HW + 1;
   // reciprocal of the slot count scaled by 2^(HW+IW); the quotient it gives
   // is the true one or one below, so one subtract corrects the remainder
   localparam logic [63:0]   RECIP_FULL = (64'd1 << (HW + IW)) / 64'(SLOTS);
   localparam logic [HW:0]   RECIP      = RECIP_FULL[HW:0];
   localparam logic [IW:0]   SLOTS_W    = (IW+1)'(SLOTS);
   localparam logic [IW-1:0] LAST_REM   = IW'(SLOTS - 1);

   typedef enum logic [1:0] {
      F_IDLE,
      F_MOD,
      F_PUSH
   } front_state_type;

   front_state_type                  state_ff, state_in;
   hsr_pkg::req_cmd_type             cmd_ff, cmd_in;
   logic [IW:0]                      quo_ff, quo_in;
   logic [IW-1:0]                    rem_ff, rem_in;
   logic [PW-1:0]                    prod;
   logic [IW:0]                      rem_raw;
   hsr_pkg::req_code_type            req_code;

   assign req_code   = hsr_pkg::req_code_type'(req.req_type);
   assign req.ready  = (state_ff == F_IDLE) && !clear_busy;
   assign push_valid = (state_ff == F_PUSH);
   assign push_cmd   = cmd_ff;
   assign push_idx   = rem_ff;

   // quotient estimate, then remainder low bits below twice the slot count
   assign prod    = PW'(req.handle_in) * PW'(RECIP);
   assign rem_raw = cmd_ff.handle[IW:0] - quo_ff * SLOTS_W;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req.valid && req.ready) begin
               cmd_in.code   = req_code;
               cmd_in.handle = req.handle_in;
               cmd_in.tag    = req.ctx_tag;
               quo_in        = prod[HW+IW +: IW+1];
               rem_in        = '0;
               if (req_code == hsr_pkg::REQ_UNREGISTER ||
                   req_code == hsr_pkg::REQ_LOOKUP) begin
                  state_in = F_MOD;
               end else begin
                  state_in = F_PUSH;
               end
            end
         end
         F_MOD: begin
            if (rem_raw >= SLOTS_W) begin
               rem_in = IW'(rem_raw - SLOTS_W);
            end else begin
               rem_in = rem_raw[IW-1:0];
            end
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff <= cmd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == F_PUSH |-> rem_ff <= LAST_REM)
      else $error("slot index out of range");

endmodule

[design/hsr_cmd_queue.sv]
// small command queue between front and back end
module hsr_cmd_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = hsr_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/hsr_back.sv]
// back end: slot table, handle allocation scan and response register
module hsr_back #(
   parameter int unsigned SLOTS = hsr_pkg::DEFAULT_SLOTS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   output logic                     q_pop,
   input  hsr_pkg::req_cmd_type     q_cmd,
   input  logic [$clog2(SLOTS)-1:0] q_idx,
   output logic                     clear_busy,
   hsr_rsp_if.source                rsp
);

   localparam int unsigned IW     = $clog2(SLOTS);
   localparam int unsigned CW     = $clog2(SLOTS + 1);
   localparam int unsigned HW     = hsr_pkg::HANDLE_W;
   localparam int unsigned WORD_W = $bits(hsr_pkg::slot_entry_type);
   localparam logic [IW-1:0] LAST_IDX  = IW'(SLOTS - 1);
   localparam logic [CW-1:0] SLOTS_CNT = CW'(SLOTS);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_PROBE,
      S_REPLY
   } back_state_type;

   back_state_type               state_ff, state_in;
   logic [IW-1:0]                clr_idx_ff, clr_idx_in;
   logic [HW-1:0]                next_handle_ff, next_handle_in;
   logic [IW-1:0]                next_idx_ff, next_idx_in;
   logic [CW-1:0]                used_ff, used_in;
   hsr_pkg::req_cmd_type         cmd_ff, cmd_in;
   logic [IW-1:0]                idx_ff, idx_in;
   logic [HW-1:0]                cand_h_ff, cand_h_in, iss_h_ff, iss_h_in;
   logic [IW-1:0]                cand_idx_ff, cand_idx_in, iss_idx_ff, iss_idx_in;
   logic [CW-1:0]                chk_ff, chk_in;
   hsr_pkg::status_type          res_status_ff, res_status_in;
   logic [HW-1:0]                res_handle_ff, res_handle_in;
   logic [hsr_pkg::TAG_W-1:0]    res_tag_ff, res_tag_in;
   logic [hsr_pkg::OCC_W-1:0]    res_occ_ff, res_occ_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   hsr_pkg::status_type          out_status_ff, out_status_in;
   logic [HW-1:0]                out_handle_ff, out_handle_in;
   logic [hsr_pkg::TAG_W-1:0]    out_tag_ff, out_tag_in;
   logic [hsr_pkg::OCC_W-1:0]    out_occ_ff, out_occ_in;

   logic                         ram_we, ram_re;
   logic [IW-1:0]                ram_waddr, ram_raddr;
   logic [WORD_W-1:0]            ram_wdata, ram_rdata;
   hsr_pkg::slot_entry_type      rd_entry, wr_entry;
   logic                         scan_hit, probe_match;

   // following candidate handle and its slot; handle zero lives in slot zero
   function automatic logic [HW+IW-1:0] next_cand(input logic [HW-1:0] h,
                                                  input logic [IW-1:0] idx);
      logic [IW-1:0] nidx;
      if (h == hsr_pkg::HANDLE_MAX || idx == LAST_IDX) begin
         nidx = '0;
      end else begin
         nidx = idx + IW'(1);
      end
      return {h + HW'(1), nidx};
   endfunction

   hsr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_entry    = hsr_pkg::slot_entry_type'(ram_rdata);
   assign ram_wdata   = wr_entry;
   assign scan_hit    = (cand_h_ff != '0) && !rd_entry.valid;
   assign probe_match = rd_entry.valid && (rd_entry.handle == cmd_ff.handle);
   assign clear_busy  = (state_ff == S_CLEAR);

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = out_status_ff;
   assign rsp.handle_out = out_handle_ff;
   assign rsp.tag_out    = out_tag_ff;
   assign rsp.occupied   = out_occ_ff;

   always_comb begin
      state_in       = state_ff;
      clr_idx_in     = clr_idx_ff;
      next_handle_in = next_handle_ff;
      next_idx_in    = next_idx_ff;
      used_in        = used_ff;
      cmd_in         = cmd_ff;
      idx_in         = idx_ff;
      cand_h_in      = cand_h_ff;
      cand_idx_in    = cand_idx_ff;
      iss_h_in       = iss_h_ff;
      iss_idx_in     = iss_idx_ff;
      chk_in         = chk_ff;
      res_status_in  = res_status_ff;
      res_handle_in  = res_handle_ff;
      res_tag_in     = res_tag_ff;
      res_occ_in     = res_occ_ff;
      rsp_valid_in   = rsp_valid_ff;
      out_status_in  = out_status_ff;
      out_handle_in  = out_handle_ff;
      out_tag_in     = out_tag_ff;
      out_occ_in     = out_occ_ff;
      q_pop          = 1'b0;
      ram_we         = 1'b0;
      ram_waddr      = idx_ff;
      wr_entry       = '0;
      ram_re         = 1'b0;
      ram_raddr      = iss_idx_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_idx_ff;
            clr_idx_in = clr_idx_ff + IW'(1);
            if (clr_idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               idx_in = q_idx;
               unique case (q_cmd.code)
                  hsr_pkg::REQ_REGISTER: begin
                     ram_re                 = 1'b1;
                     ram_raddr              = next_idx_ff;
                     cand_h_in              = next_handle_ff;
                     cand_idx_in            = next_idx_ff;
                     {iss_h_in, iss_idx_in} = next_cand(next_handle_ff, next_idx_ff);
                     chk_in                 = CW'(1);
                     state_in               = S_SCAN;
                  end
                  hsr_pkg::REQ_UNREGISTER, hsr_pkg::REQ_LOOKUP: begin
                     ram_re    = 1'b1;
                     ram_raddr = q_idx;
                     state_in  = S_PROBE;
                  end
                  hsr_pkg::REQ_COUNT: begin
                     res_status_in = hsr_pkg::STAT_OK;
                     res_handle_in = '0;
                     res_tag_in    = '0;
                     res_occ_in    = hsr_pkg::OCC_W'(used_ff);
                     state_in      = S_REPLY;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (scan_hit) begin
               ram_we          = 1'b1;
               ram_waddr       = cand_idx_ff;
               wr_entry.valid  = 1'b1;
               wr_entry.handle = cand_h_ff;
               wr_entry.tag    = cmd_ff.tag;
               {next_handle_in, next_idx_in} = next_cand(cand_h_ff, cand_idx_ff);
               used_in         = used_ff + CW'(1);
               res_status_in   = hsr_pkg::STAT_OK;
               res_handle_in   = cand_h_ff;
               res_tag_in      = '0;
               res_occ_in      = hsr_pkg::OCC_W'(used_ff + CW'(1));
               state_in        = S_REPLY;
            end else if (chk_ff == SLOTS_CNT) begin
               res_status_in = hsr_pkg::STAT_FULL;
               res_handle_in = '0;
               res_tag_in    = '0;
               res_occ_in    = hsr_pkg::OCC_W'(used_ff);
               state_in      = S_REPLY;
            end else begin
               ram_re                 = 1'b1;
               ram_raddr              = iss_idx_ff;
               cand_h_in              = iss_h_ff;
               cand_idx_in            = iss_idx_ff;
               {iss_h_in, iss_idx_in} = next_cand(iss_h_ff, iss_idx_ff);
               chk_in                 = chk_ff + CW'(1);
            end
         end
         S_PROBE: begin
            res_handle_in = '0;
            res_tag_in    = '0;
            res_occ_in    = hsr_pkg::OCC_W'(used_ff);
            state_in      = S_REPLY;
            if (!probe_match) begin
               res_status_in = hsr_pkg::STAT_NOT_FOUND;
            end else begin
               res_status_in = hsr_pkg::STAT_OK;
               if (cmd_ff.code == hsr_pkg::REQ_UNREGISTER) begin
                  ram_we          = 1'b1;
                  ram_waddr       = idx_ff;
                  wr_entry.valid  = 1'b0;
                  wr_entry.handle = rd_entry.handle;
                  wr_entry.tag    = rd_entry.tag;
                  used_in         = used_ff - CW'(1);
                  res_occ_in      = hsr_pkg::OCC_W'(used_ff - CW'(1));
               end else begin
                  res_tag_in = rd_entry.tag;
               end
            end
         end
         S_REPLY: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_handle_in = res_handle_ff;
               out_tag_in    = res_tag_ff;
               out_occ_in    = res_occ_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_idx_ff     <= '0;
         next_handle_ff <= HW'(1);
         next_idx_ff    <= IW'(1);
         used_ff        <= '0;
         chk_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_idx_ff     <= clr_idx_in;
         next_handle_ff <= next_handle_in;
         next_idx_ff    <= next_idx_in;
         used_ff        <= used_in;
         chk_ff         <= chk_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      cand_h_ff     <= cand_h_in;
      cand_idx_ff   <= cand_idx_in;
      iss_h_ff      <= iss_h_in;
      iss_idx_ff    <= iss_idx_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_tag_ff    <= res_tag_in;
      res_occ_ff    <= res_occ_in;
      out_status_ff <= out_status_in;
      out_handle_ff <= out_handle_in;
      out_tag_ff    <= out_tag_in;
      out_occ_ff    <= out_occ_in;
   end

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= SLOTS_CNT)
      else $error("occupancy above slot count");

   a_next_idx_range: assert property (@(posedge clock) disable iff (reset)
      next_idx_ff <= LAST_IDX)
      else $error("next slot index out of range");

   a_scan_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> (chk_ff != '0) && (chk_ff <= SLOTS_CNT))
      else $error("scan ran past slot count");

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && $past(state_ff) == S_CLEAR) |-> used_ff == '0)
      else $error("table not empty after clearing pass");

endmodule

[design/handle_slot_registry_unit.sv]
// top level of the handle slot registry: front end, command queue, back end
//
// usage
//   req_ch carries one request per beat: req_type, handle_in, ctx_tag
//   rsp_ch returns exactly one response beat per request, in request order:
//   status, handle_out, tag_out, occupied
// reset
//   synchronous; afterwards the slot ram is swept clear, one slot a cycle,
//   through all SLOTS slots, and req_ch.ready stays low during that sweep
// sequence
//   front end: register and count beats go from idle straight to push;
//   unregister and lookup beats pass a modulo state first (slot index
//   from a reciprocal multiply, then one correction)
//   back end: count goes from idle straight to reply, unregister and lookup
//   pass a probe first, register reads one slot per candidate, up to SLOTS
// stalls
//   a two-entry command queue decouples front and back; the response sits
//   in an output register, so requests keep flowing into the queue while
//   rsp_ch.ready is low until the queue fills
module handle_slot_registry_unit #(
   parameter int unsigned SLOTS = hsr_pkg::DEFAULT_SLOTS
) (
   input  logic      clock,
   input  logic      reset,
   hsr_req_if.sink   req_ch,
   hsr_rsp_if.source rsp_ch
);

   localparam int unsigned IW    = $clog2(SLOTS);
   localparam int unsigned CMD_W = $bits(hsr_pkg::req_cmd_type);
   localparam int unsigned Q_W   = CMD_W + IW;

   // front to queue
   logic                 push_valid, push_ready;
   hsr_pkg::req_cmd_type push_cmd;
   logic [IW-1:0]        push_idx;

   // queue to back
   logic                 pop_valid, pop;
   logic [Q_W-1:0]       pop_data;
   hsr_pkg::req_cmd_type pop_cmd;
   logic [IW-1:0]        pop_idx;

   // back end sweeping the table after reset
   logic                 clear_busy;

   assign pop_cmd = hsr_pkg::req_cmd_type'(pop_data[Q_W-1:IW]);
   assign pop_idx = pop_data[IW-1:0];

   hsr_front #(
      .SLOTS (SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .clear_busy (clear_busy),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .push_idx   (push_idx)
   );

   hsr_cmd_queue #(
      .WIDTH (Q_W),
      .DEPTH (hsr_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_cmd, push_idx}),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data)
   );

   hsr_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (pop_valid),
      .q_pop      (pop),
      .q_cmd      (pop_cmd),
      .q_idx      (pop_idx),
      .clear_busy (clear_busy),
      .rsp        (rsp_ch)
   );

endmodule
